>>> hw/rtl/rru_pkg.sv
`timescale 1ns / 1ps

package rru_pkg;

    // Field widths of the request and result channels
    localparam int OP_W     = 2;
    localparam int PC_W     = 32;
    localparam int REG_W    = 7;
    localparam int TAG_W    = 6;
    localparam int STATUS_W = 2;

    // Default sizes of the reorder buffer and the architectural register file
    localparam int ROB_DEPTH_DEF     = 64;
    localparam int NUM_ARCH_REGS_DEF = 128;

    typedef enum logic [OP_W-1:0] {
        OP_RENAME   = 2'd0,
        OP_COMPLETE = 2'd1,
        OP_RETIRE   = 2'd2,
        OP_NOP      = 2'd3
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 2'd0,
        ST_FULL     = 2'd1,
        ST_NOT_DONE = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_CHECK
    } state_t;

    // One reorder buffer entry as held in the entry memory
    typedef struct packed {
        logic             dest_present;
        logic [REG_W-1:0] dest;
        logic [PC_W-1:0]  pc;
    } rob_entry_t;

    // One result as held in the output register
    typedef struct packed {
        status_t          status;
        logic [TAG_W-1:0] alloc_tag;
        logic             src1_from_rob;
        logic [TAG_W-1:0] src1_tag;
        logic             src1_ready;
        logic             src2_from_rob;
        logic [TAG_W-1:0] src2_tag;
        logic             src2_ready;
        logic             retired_dest_present;
        logic [REG_W-1:0] retired_dest;
        logic [PC_W-1:0]  retired_pc;
    } res_t;

endpackage

>>> hw/rtl/rru_if.sv
`timescale 1ns / 1ps

// Request channel: rename, complete or retire
interface rru_req_if;
    logic                         valid;
    logic                         ready;
    logic [rru_pkg::OP_W-1:0]     op;
    logic [rru_pkg::PC_W-1:0]     pc;
    logic                         dest_present;
    logic [rru_pkg::REG_W-1:0]    dest_arch;
    logic                         src1_present;
    logic [rru_pkg::REG_W-1:0]    src1_arch;
    logic                         src2_present;
    logic [rru_pkg::REG_W-1:0]    src2_arch;
    logic [rru_pkg::TAG_W-1:0]    done_tag;

    modport source (
        output valid, op, pc, dest_present, dest_arch, src1_present, src1_arch,
               src2_present, src2_arch, done_tag,
        input  ready
    );

    modport sink (
        input  valid, op, pc, dest_present, dest_arch, src1_present, src1_arch,
               src2_present, src2_arch, done_tag,
        output ready
    );
endinterface

// Result channel: one result per request
interface rru_res_if;
    logic                         valid;
    logic                         ready;
    logic [rru_pkg::STATUS_W-1:0] status;
    logic [rru_pkg::TAG_W-1:0]    alloc_tag;
    logic                         src1_from_rob;
    logic [rru_pkg::TAG_W-1:0]    src1_tag;
    logic                         src1_ready;
    logic                         src2_from_rob;
    logic [rru_pkg::TAG_W-1:0]    src2_tag;
    logic                         src2_ready;
    logic                         retired_dest_present;
    logic [rru_pkg::REG_W-1:0]    retired_dest;
    logic [rru_pkg::PC_W-1:0]     retired_pc;

    modport source (
        output valid, status, alloc_tag, src1_from_rob, src1_tag, src1_ready,
               src2_from_rob, src2_tag, src2_ready, retired_dest_present,
               retired_dest, retired_pc,
        input  ready
    );

    modport sink (
        input  valid, status, alloc_tag, src1_from_rob, src1_tag, src1_ready,
               src2_from_rob, src2_tag, src2_ready, retired_dest_present,
               retired_dest, retired_pc,
        output ready
    );
endinterface

>>> hw/rtl/rob_register_rename_unit.sv
`timescale 1ns / 1ps

// Register rename map and circular reorder buffer.
// req carries one request: rename (look up both sources, allocate the tail
// entry, remap the destination), complete (mark a tag done, drop its map
// entry if it still points there) or retire (free the head entry once done).
// rsp returns exactly one result per request, in request order.
// A rename, retire or no-op request is read on acceptance and finished in S_EXEC,
// which registers its result; a complete goes on to S_CHECK and registers its
// result there, since it reads the entry memory and then the map memory at the
// destination it found. The block takes no new request until the held one is
// finished; each request waits on the registered read of the map tag and entry
// memories and writes back before the next request is read.
// The block takes a new request while a finished result still sits in the
// output register; if rsp is stalled, the next result waits in the block and
// req stays low until the output register frees.
// Reset clears the map valid bits, the done bits, head, tail and occupancy
// at once; the tag and entry memories need no clearing pass, so req may
// be taken from the first cycle after reset.
module rob_register_rename_unit #(
    parameter int ROB_DEPTH     = rru_pkg::ROB_DEPTH_DEF,
    parameter int NUM_ARCH_REGS = rru_pkg::NUM_ARCH_REGS_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    rru_req_if.sink      req,
    rru_res_if.source    rsp
);

    localparam int PW = (ROB_DEPTH > 1) ? $clog2(ROB_DEPTH) : 1;
    localparam int CW = $clog2(ROB_DEPTH + 1);
    localparam int AW = (NUM_ARCH_REGS > 1) ? $clog2(NUM_ARCH_REGS) : 1;

    // Control state
    rru_pkg::state_t             state_reg;
    rru_pkg::state_t             state_next;
    logic [NUM_ARCH_REGS-1:0]    map_valid_reg;
    logic [ROB_DEPTH-1:0]        done_reg;
    logic [PW-1:0]               head_reg;
    logic [PW-1:0]               tail_reg;
    logic [CW-1:0]               occ_reg;
    logic                        out_valid_reg;

    // Held request
    rru_pkg::op_t                op_reg;
    logic [rru_pkg::PC_W-1:0]    pc_reg;
    logic                        dest_use_reg;
    logic [AW-1:0]               dest_idx_reg;
    logic [rru_pkg::REG_W-1:0]   dest_field_reg;
    logic                        src1_use_reg;
    logic [AW-1:0]               src1_idx_reg;
    logic                        src2_use_reg;
    logic [AW-1:0]               src2_idx_reg;
    logic                        tag_in_range_reg;
    logic [PW-1:0]               tag_idx_reg;

    // Memories and their registered read data
    logic [PW-1:0]               map_tag_mem [NUM_ARCH_REGS];
    rru_pkg::rob_entry_t         rob_mem [ROB_DEPTH];
    logic [PW-1:0]               map_a_q;
    logic [PW-1:0]               map_b_q;
    rru_pkg::rob_entry_t         rob_q;

    rru_pkg::res_t               res_reg;
    rru_pkg::res_t               res_next;

    logic                        accept;
    logic                        out_free;
    logic                        finish;
    logic                        chk_rd;
    logic [AW-1:0]               map_a_addr;
    logic [PW-1:0]               rob_addr;
    logic                        full;
    logic                        rename_ok;
    logic                        retire_ok;
    logic                        s1_hit;
    logic                        s2_hit;
    logic [PW:0]                 tag_off;
    logic                        in_flight;
    logic                        map_clear;
    logic [AW-1:0]               rob_dest_idx;
    logic [PW-1:0]               tail_inc;
    logic [PW-1:0]               head_inc;

    assign accept   = req.valid && req.ready;
    assign out_free = !out_valid_reg || rsp.ready;

    // Sequence one request through read, optional map check and write back
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= rru_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        req.ready  = 1'b0;
        finish     = 1'b0;
        chk_rd     = 1'b0;
        unique case (state_reg)
            rru_pkg::S_IDLE:
            begin
                req.ready = 1'b1;
                if (req.valid)
                begin
                    state_next = rru_pkg::S_EXEC;
                end
            end
            rru_pkg::S_EXEC:
            begin
                if (op_reg == rru_pkg::OP_COMPLETE)
                begin
                    chk_rd     = 1'b1;
                    state_next = rru_pkg::S_CHECK;
                end
                else if (out_free)
                begin
                    finish     = 1'b1;
                    state_next = rru_pkg::S_IDLE;
                end
            end
            rru_pkg::S_CHECK:
            begin
                if (out_free)
                begin
                    finish     = 1'b1;
                    state_next = rru_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = rru_pkg::S_IDLE;
            end
        endcase
    end

    // Hold the request fields
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg           <= rru_pkg::op_t'(req.op);
            pc_reg           <= req.pc;
            dest_use_reg     <= req.dest_present && (32'(req.dest_arch) < NUM_ARCH_REGS);
            dest_idx_reg     <= AW'(req.dest_arch);
            dest_field_reg   <= req.dest_arch;
            src1_use_reg     <= req.src1_present && (32'(req.src1_arch) < NUM_ARCH_REGS);
            src1_idx_reg     <= AW'(req.src1_arch);
            src2_use_reg     <= req.src2_present && (32'(req.src2_arch) < NUM_ARCH_REGS);
            src2_idx_reg     <= AW'(req.src2_arch);
            tag_in_range_reg <= 32'(req.done_tag) < ROB_DEPTH;
            tag_idx_reg      <= PW'(req.done_tag);
        end
    end

    // Read addresses: sources on request, destination of the entry on check
    assign rob_dest_idx = AW'(rob_q.dest);
    assign map_a_addr   = chk_rd ? rob_dest_idx : AW'(req.src1_arch);
    assign rob_addr     = (rru_pkg::op_t'(req.op) == rru_pkg::OP_RETIRE) ?
                          head_reg : PW'(req.done_tag);

    // Map tag memory: two read ports, one write port
    always_ff @(posedge clk)
    begin
        if (finish && rename_ok && dest_use_reg)
        begin
            map_tag_mem[dest_idx_reg] <= tail_reg;
        end
        if (accept || chk_rd)
        begin
            map_a_q <= map_tag_mem[map_a_addr];
        end
        if (accept)
        begin
            map_b_q <= map_tag_mem[AW'(req.src2_arch)];
        end
    end

    // Entry memory: one read port, one write port
    always_ff @(posedge clk)
    begin
        if (finish && rename_ok)
        begin
            rob_mem[tail_reg] <= '{dest_present: dest_use_reg,
                                   dest:         dest_use_reg ? dest_field_reg : '0,
                                   pc:           pc_reg};
        end
        if (accept)
        begin
            rob_q <= rob_mem[rob_addr];
        end
    end

    // Work out the result and the state changes of the held request
    assign full      = occ_reg == CW'(ROB_DEPTH);
    assign rename_ok = (op_reg == rru_pkg::OP_RENAME) && !full;
    assign retire_ok = (op_reg == rru_pkg::OP_RETIRE) && (occ_reg != '0) &&
                       done_reg[head_reg];
    assign s1_hit    = src1_use_reg && map_valid_reg[src1_idx_reg];
    assign s2_hit    = src2_use_reg && map_valid_reg[src2_idx_reg];

    assign tag_off   = (tag_idx_reg >= head_reg) ?
                       ({1'b0, tag_idx_reg} - {1'b0, head_reg}) :
                       ({1'b0, tag_idx_reg} + (PW+1)'(ROB_DEPTH) - {1'b0, head_reg});
    assign in_flight = tag_in_range_reg && (tag_off < (PW+1)'(occ_reg));
    assign map_clear = in_flight && rob_q.dest_present &&
                       (32'(rob_q.dest) < NUM_ARCH_REGS) &&
                       map_valid_reg[rob_dest_idx] && (map_a_q == tag_idx_reg);

    assign tail_inc  = (tail_reg == PW'(ROB_DEPTH - 1)) ? '0 : tail_reg + 1'b1;
    assign head_inc  = (head_reg == PW'(ROB_DEPTH - 1)) ? '0 : head_reg + 1'b1;

    always_comb
    begin
        res_next = '0;
        case (op_reg) inside
            rru_pkg::OP_RENAME:
            begin
                if (full)
                begin
                    res_next.status = rru_pkg::ST_FULL;
                end
                else
                begin
                    res_next.status        = rru_pkg::ST_OK;
                    res_next.alloc_tag     = rru_pkg::TAG_W'(tail_reg);
                    res_next.src1_from_rob = s1_hit;
                    res_next.src1_tag      = s1_hit ? rru_pkg::TAG_W'(map_a_q) : '0;
                    res_next.src1_ready    = s1_hit ? done_reg[map_a_q] : 1'b1;
                    res_next.src2_from_rob = s2_hit;
                    res_next.src2_tag      = s2_hit ? rru_pkg::TAG_W'(map_b_q) : '0;
                    res_next.src2_ready    = s2_hit ? done_reg[map_b_q] : 1'b1;
                end
            end
            rru_pkg::OP_RETIRE:
            begin
                if (retire_ok)
                begin
                    res_next.status               = rru_pkg::ST_OK;
                    res_next.retired_dest_present = rob_q.dest_present;
                    res_next.retired_dest         = rob_q.dest;
                    res_next.retired_pc           = rob_q.pc;
                end
                else
                begin
                    res_next.status = rru_pkg::ST_NOT_DONE;
                end
            end
            rru_pkg::OP_COMPLETE,
            rru_pkg::OP_NOP:
            begin
                res_next.status = rru_pkg::ST_OK;
            end
            default:
            begin
                res_next.status = rru_pkg::ST_OK;
            end
        endcase
    end

    // Update map valid bits, done bits, pointers and occupancy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            map_valid_reg <= '0;
            done_reg      <= '0;
            head_reg      <= '0;
            tail_reg      <= '0;
            occ_reg       <= '0;
        end
        else if (finish)
        begin
            if (rename_ok)
            begin
                done_reg[tail_reg] <= 1'b0;
                if (dest_use_reg)
                begin
                    map_valid_reg[dest_idx_reg] <= 1'b1;
                end
                tail_reg <= tail_inc;
                occ_reg  <= occ_reg + 1'b1;
            end
            if ((op_reg == rru_pkg::OP_COMPLETE) && in_flight)
            begin
                done_reg[tag_idx_reg] <= 1'b1;
                if (map_clear)
                begin
                    map_valid_reg[rob_dest_idx] <= 1'b0;
                end
            end
            if (retire_ok)
            begin
                done_reg[head_reg] <= 1'b0;
                head_reg <= head_inc;
                occ_reg  <= occ_reg - 1'b1;
            end
        end
    end

    // Output register: load on finish, drop when taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (finish)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (finish)
        begin
            res_reg <= res_next;
        end
    end

    assign rsp.valid                = out_valid_reg;
    assign rsp.status               = res_reg.status;
    assign rsp.alloc_tag            = res_reg.alloc_tag;
    assign rsp.src1_from_rob        = res_reg.src1_from_rob;
    assign rsp.src1_tag             = res_reg.src1_tag;
    assign rsp.src1_ready           = res_reg.src1_ready;
    assign rsp.src2_from_rob        = res_reg.src2_from_rob;
    assign rsp.src2_tag             = res_reg.src2_tag;
    assign rsp.src2_ready           = res_reg.src2_ready;
    assign rsp.retired_dest_present = res_reg.retired_dest_present;
    assign rsp.retired_dest         = res_reg.retired_dest;
    assign rsp.retired_pc           = res_reg.retired_pc;

    // Occupancy never passes the buffer depth
    a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
        occ_reg <= CW'(ROB_DEPTH))
        else $error("occupancy above buffer depth");

    // An empty buffer has head and tail together
    a_empty_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
        (occ_reg == '0) |-> (head_reg == tail_reg))
        else $error("empty buffer with head and tail apart");

    // A finished request leaves a result waiting and the sequencer idle
    a_finish: assert property (@(posedge clk) disable iff (!rst_n)
        finish |=> (out_valid_reg && (state_reg == rru_pkg::S_IDLE)))
        else $error("result not presented after finish");

    // A result is only written over once the previous one has gone
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !rsp.ready) |-> !finish)
        else $error("result overwritten while stalled");

endmodule

>>> test/rru_checker.sv
`timescale 1ns / 1ps

// Watch the request and result channels of the rename unit, predict every result
// from its own copy of the map table and reorder buffer, and compare in order.
module rru_checker
    import rru_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    rru_req_if                       req,
    rru_res_if                       rsp,
    output int                       mismatches,
    output int                       outstanding,
    output logic [TAG_W-1:0]         buf_head,
    output logic [TAG_W:0]           rob_count,
    output logic [ROB_DEPTH_DEF-1:0] tags_written,
    output int                       full_renames,
    output int                       refused_retires,
    output int                       retirements
);

    localparam int ROB_DEPTH = ROB_DEPTH_DEF;
    localparam int NUM_REGS  = NUM_ARCH_REGS_DEF;

    // Predicted state of the map table and the reorder buffer
    logic                 map_valid  [NUM_REGS];
    logic [TAG_W-1:0]     map_tag    [NUM_REGS];
    logic                 entry_done [ROB_DEPTH];
    rob_entry_t           entry      [ROB_DEPTH];
    logic [TAG_W-1:0]     head;
    logic [TAG_W-1:0]     tail;
    logic [TAG_W:0]       occupancy;
    logic [ROB_DEPTH-1:0] written;

    // Results predicted for accepted requests, oldest first
    res_t predicted_results [$];

    // Resolve one source: in-flight producer tag or the architectural file
    function automatic void look_up_source(
        input  logic             present,
        input  logic [REG_W-1:0] areg,
        output logic             from_rob,
        output logic [TAG_W-1:0] tag,
        output logic             ready
    );
        from_rob = 1'b0;
        tag      = '0;
        ready    = 1'b1;
        if (present && map_valid[areg])
        begin
            from_rob = 1'b1;
            tag      = map_tag[areg];
            ready    = entry_done[map_tag[areg]];
        end
    endfunction

    // Apply one request to the predicted state and return its result
    function automatic res_t advance_rob(
        input op_t              op,
        input logic [PC_W-1:0]  pc,
        input logic             dest_present,
        input logic [REG_W-1:0] dest_arch,
        input logic             src1_present,
        input logic [REG_W-1:0] src1_arch,
        input logic             src2_present,
        input logic [REG_W-1:0] src2_arch,
        input logic [TAG_W-1:0] done_tag
    );
        res_t             r;
        logic [TAG_W-1:0] offset;
        logic [REG_W-1:0] d;
        r = '0;
        case (op)
            OP_RENAME:
            begin
                if (occupancy >= ROB_DEPTH)
                begin
                    r.status = ST_FULL;
                    full_renames++;
                end
                else
                begin
                    // Sources are looked up before the destination is remapped
                    look_up_source(src1_present, src1_arch,
                                   r.src1_from_rob, r.src1_tag, r.src1_ready);
                    look_up_source(src2_present, src2_arch,
                                   r.src2_from_rob, r.src2_tag, r.src2_ready);
                    entry_done[tail] = 1'b0;
                    entry[tail].dest_present = dest_present;
                    entry[tail].dest = dest_present ? dest_arch : '0;
                    entry[tail].pc = pc;
                    written[tail] = 1'b1;
                    if (dest_present)
                    begin
                        map_valid[dest_arch] = 1'b1;
                        map_tag[dest_arch]   = tail;
                    end
                    r.alloc_tag = tail;
                    // Depth is a power of two, so the pointer wraps by itself
                    tail = tail + 1'b1;
                    occupancy = occupancy + 1'b1;
                end
            end
            OP_COMPLETE:
            begin
                // Only tags between head and tail are in flight
                offset = done_tag - head;
                if (offset < occupancy)
                begin
                    entry_done[done_tag] = 1'b1;
                    d = entry[done_tag].dest;
                    if (entry[done_tag].dest_present && map_valid[d]
                        && map_tag[d] == done_tag)
                        map_valid[d] = 1'b0;
                end
            end
            OP_RETIRE:
            begin
                if (occupancy == 0 || !entry_done[head])
                begin
                    r.status = ST_NOT_DONE;
                    refused_retires++;
                end
                else
                begin
                    r.retired_dest_present = entry[head].dest_present;
                    r.retired_dest         = entry[head].dest;
                    r.retired_pc           = entry[head].pc;
                    entry_done[head] = 1'b0;
                    head = head + 1'b1;
                    occupancy = occupancy - 1'b1;
                    retirements++;
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    // Flag one field that differs from its prediction
    function automatic void compare_field(
        input string           field,
        input logic [PC_W-1:0] want,
        input logic [PC_W-1:0] got
    );
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h",
                     $time, field, want, got);
            mismatches++;
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        res_t want;
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_REGS; i++)
            begin
                map_valid[i] = 1'b0;
                map_tag[i]   = '0;
            end
            for (int i = 0; i < ROB_DEPTH; i++)
                entry_done[i] = 1'b0;
            head      = '0;
            tail      = '0;
            occupancy = '0;
            written   = '0;
            predicted_results.delete();
            mismatches      = 0;
            full_renames    = 0;
            refused_retires = 0;
            retirements     = 0;
            outstanding  <= 0;
            buf_head     <= '0;
            rob_count    <= '0;
            tags_written <= '0;
        end
        else
        begin
            // Compare a returned result with the oldest prediction
            if (rsp.valid && rsp.ready)
            begin
                if (predicted_results.size() == 0)
                begin
                    $display("%0t: unexpected result, expected none, got status %0d",
                             $time, rsp.status);
                    mismatches++;
                end
                else
                begin
                    want = predicted_results.pop_front();
                    compare_field("status", want.status, rsp.status);
                    compare_field("alloc_tag", want.alloc_tag, rsp.alloc_tag);
                    compare_field("src1_from_rob", want.src1_from_rob, rsp.src1_from_rob);
                    compare_field("src1_tag", want.src1_tag, rsp.src1_tag);
                    compare_field("src1_ready", want.src1_ready, rsp.src1_ready);
                    compare_field("src2_from_rob", want.src2_from_rob, rsp.src2_from_rob);
                    compare_field("src2_tag", want.src2_tag, rsp.src2_tag);
                    compare_field("src2_ready", want.src2_ready, rsp.src2_ready);
                    compare_field("retired_dest_present", want.retired_dest_present,
                                  rsp.retired_dest_present);
                    compare_field("retired_dest", want.retired_dest, rsp.retired_dest);
                    compare_field("retired_pc", want.retired_pc, rsp.retired_pc);
                end
            end

            // Predict the result of an accepted request
            if (req.valid && req.ready)
                predicted_results.push_back(advance_rob(op_t'(req.op), req.pc,
                    req.dest_present, req.dest_arch, req.src1_present, req.src1_arch,
                    req.src2_present, req.src2_arch, req.done_tag));

            // Publish a view of the buffer for steering the stimulus
            outstanding  <= predicted_results.size();
            buf_head     <= head;
            rob_count    <= occupancy;
            tags_written <= written;
        end
    end

endmodule

>>> test/tb.sv
`timescale 1ns / 1ps

module tb;
    import rru_pkg::*;

    localparam int WATCHDOG_LIMIT = 500;
    localparam int RANDOM_PHASES  = 10;
    localparam int PHASE_LEN      = 100;
    localparam int DRAIN_CYCLES   = 10;

    typedef enum int {
        PH_FILL,
        PH_FLOW,
        PH_DRAIN,
        PH_NOISE
    } phase_t;

    logic clk = 1'b0;
    logic rst_n;
    logic req_idling;
    logic rsp_idling;
    int   stall_cycles = 0;
    int   sent_by_op [4];

    int                       mismatches;
    int                       outstanding;
    logic [TAG_W-1:0]         buf_head;
    logic [TAG_W:0]           rob_count;
    logic [ROB_DEPTH_DEF-1:0] tags_written;
    int                       full_renames;
    int                       refused_retires;
    int                       retirements;

    rru_req_if req_ch ();
    rru_res_if rsp_ch ();

    rob_register_rename_unit u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    rru_checker u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .req             (req_ch),
        .rsp             (rsp_ch),
        .mismatches      (mismatches),
        .outstanding     (outstanding),
        .buf_head        (buf_head),
        .rob_count       (rob_count),
        .tags_written    (tags_written),
        .full_renames    (full_renames),
        .refused_retires (refused_retires),
        .retirements     (retirements)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Count cycles in which neither channel moves a request or a result
    always @(posedge clk)
    begin
        if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
    end

    initial
    begin
        while (stall_cycles < WATCHDOG_LIMIT)
            @(posedge clk);
        $display("%0t: no handshake for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("RESULT: ERROR");
        $finish;
    end

    // Take results, holding ready low for a random number of cycles first
    initial
    begin
        int hold;
        rsp_ch.ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            hold = rsp_idling ? $urandom_range(0, 7) : 0;
            if (hold > 0)
            begin
                rsp_ch.ready <= 1'b0;
                repeat (hold) @(posedge clk);
            end
            rsp_ch.ready <= 1'b1;
            @(posedge clk);
            while (!rsp_ch.valid)
                @(posedge clk);
        end
    end

    // Drive one request after a random gap and hold it until it is taken
    task automatic send_request(
        input op_t              op,
        input logic [PC_W-1:0]  pc,
        input logic             dest_present,
        input logic [REG_W-1:0] dest_arch,
        input logic             src1_present,
        input logic [REG_W-1:0] src1_arch,
        input logic             src2_present,
        input logic [REG_W-1:0] src2_arch,
        input logic [TAG_W-1:0] done_tag
    );
        int gap;
        gap = req_idling ? $urandom_range(0, 7) : 0;
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_ch.valid        <= 1'b1;
        req_ch.op           <= op;
        req_ch.pc           <= pc;
        req_ch.dest_present <= dest_present;
        req_ch.dest_arch    <= dest_arch;
        req_ch.src1_present <= src1_present;
        req_ch.src1_arch    <= src1_arch;
        req_ch.src2_present <= src2_present;
        req_ch.src2_arch    <= src2_arch;
        req_ch.done_tag     <= done_tag;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        sent_by_op[op]++;
    endtask

    // Favour a few registers so that sources hit in-flight producers
    function automatic logic [REG_W-1:0] pick_reg();
        if ($urandom_range(0, 3) != 0)
            return REG_W'($urandom_range(0, 7));
        return REG_W'($urandom_range(0, NUM_ARCH_REGS_DEF - 1));
    endfunction

    // Draw one request with an operation mix that suits the phase
    task automatic send_random_request(input phase_t phase);
        int               pick;
        int               span;
        op_t              op;
        logic [TAG_W-1:0] tag;
        pick = $urandom_range(0, 99);
        case (phase)
            PH_FILL:
                op = pick < 80 ? OP_RENAME : pick < 90 ? OP_COMPLETE :
                     pick < 95 ? OP_RETIRE : OP_NOP;
            PH_FLOW:
                op = pick < 35 ? OP_RENAME : pick < 70 ? OP_COMPLETE :
                     pick < 95 ? OP_RETIRE : OP_NOP;
            PH_DRAIN:
                op = pick < 10 ? OP_RENAME : pick < 55 ? OP_COMPLETE : OP_RETIRE;
            default:
                op = op_t'(pick % 4);
        endcase

        // Complete mostly in-flight tags, often those near the head
        tag = TAG_W'($urandom_range(0, ROB_DEPTH_DEF - 1));
        if (phase != PH_NOISE && rob_count != 0 && $urandom_range(0, 7) != 0)
        begin
            span = (rob_count > 4 && $urandom_range(0, 1) == 1) ? 4 : int'(rob_count);
            tag = buf_head + TAG_W'($urandom_range(0, span - 1));
        end
        // Never point a complete at an entry that was never written
        if (op == OP_COMPLETE && !tags_written[tag])
            op = OP_RETIRE;

        send_request(op, $urandom(), $urandom_range(0, 3) != 0, pick_reg(),
                     $urandom_range(0, 3) != 0, pick_reg(),
                     $urandom_range(0, 3) != 0, pick_reg(), tag);
    endtask

    initial
    begin
        phase_t phase;
        rst_n               <= 1'b0;
        req_ch.valid        <= 1'b0;
        req_ch.op           <= OP_NOP;
        req_ch.pc           <= '0;
        req_ch.dest_present <= 1'b0;
        req_ch.dest_arch    <= '0;
        req_ch.src1_present <= 1'b0;
        req_ch.src1_arch    <= '0;
        req_ch.src2_present <= 1'b0;
        req_ch.src2_arch    <= '0;
        req_ch.done_tag     <= '0;
        req_idling          <= 1'b1;
        rsp_idling          <= 1'b1;
        for (int i = 0; i < 4; i++)
            sent_by_op[i] = 0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Retire with an empty buffer
        send_request(OP_RETIRE, '0, 1'b0, '0, 1'b0, '0, 1'b0, '0, '0);
        // Nothing used; then sources from the register file at both index extremes
        send_request(OP_RENAME, 32'h0000_0000, 1'b0, 7'd0, 1'b0, 7'd0, 1'b0, 7'd0, '0);
        send_request(OP_RENAME, 32'hFFFF_FFFF, 1'b1, 7'd127, 1'b1, 7'd0, 1'b1, 7'd127, '0);
        // First source from an in-flight producer, second source unused
        send_request(OP_RENAME, 32'h5555_5555, 1'b1, 7'd0, 1'b1, 7'd127, 1'b0, 7'd127, '0);
        // Head not yet done
        send_request(OP_RETIRE, '0, 1'b0, '0, 1'b0, '0, 1'b0, '0, '0);
        // Complete the head twice, retire it, then complete it again once freed
        send_request(OP_COMPLETE, '0, 1'b0, '0, 1'b0, '0, 1'b0, '0, 6'd0);
        send_request(OP_COMPLETE, '0, 1'b0, '0, 1'b0, '0, 1'b0, '0, 6'd0);
        send_request(OP_RETIRE, '0, 1'b0, '0, 1'b0, '0, 1'b0, '0, '0);
        send_request(OP_COMPLETE, '0, 1'b0, '0, 1'b0, '0, 1'b0, '0, 6'd0);
        // Complete clears the map entry that still points at it
        send_request(OP_COMPLETE, '0, 1'b0, '0, 1'b0, '0, 1'b0, '0, 6'd1);
        send_request(OP_RENAME, 32'hAAAA_AAAA, 1'b0, 7'd127, 1'b1, 7'd127, 1'b1, 7'd0, '0);
        // Remap a register, then complete its older producer: map must stay
        send_request(OP_RENAME, 32'h1234_5678, 1'b1, 7'd0, 1'b1, 7'd0, 1'b1, 7'd1, '0);
        send_request(OP_COMPLETE, '0, 1'b0, '0, 1'b0, '0, 1'b0, '0, 6'd2);
        send_request(OP_RENAME, 32'h8000_0001, 1'b1, 7'd5, 1'b1, 7'd0, 1'b1, 7'd5, '0);
        send_request(OP_RETIRE, '0, 1'b0, '0, 1'b0, '0, 1'b0, '0, '0);
        send_request(OP_RETIRE, '0, 1'b0, '0, 1'b0, '0, 1'b0, '0, '0);
        send_request(OP_RETIRE, '0, 1'b0, '0, 1'b0, '0, 1'b0, '0, '0);
        // No operation with every field set
        send_request(OP_NOP, 32'hFFFF_FFFF, 1'b1, 7'd127, 1'b1, 7'd127, 1'b1, 7'd127,
                     6'd63);
        // Complete an entry that has already retired, then drain the rest
        send_request(OP_COMPLETE, '0, 1'b0, '0, 1'b0, '0, 1'b0, '0, 6'd1);
        send_request(OP_COMPLETE, '0, 1'b0, '0, 1'b0, '0, 1'b0, '0, 6'd5);
        send_request(OP_COMPLETE, '0, 1'b0, '0, 1'b0, '0, 1'b0, '0, 6'd4);
        send_request(OP_COMPLETE, '0, 1'b0, '0, 1'b0, '0, 1'b0, '0, 6'd3);
        send_request(OP_RETIRE, '0, 1'b0, '0, 1'b0, '0, 1'b0, '0, '0);
        send_request(OP_RETIRE, '0, 1'b0, '0, 1'b0, '0, 1'b0, '0, '0);
        send_request(OP_RETIRE, '0, 1'b0, '0, 1'b0, '0, 1'b0, '0, '0);

        // Random phases: fill the buffer first, then mix flow, drain and noise
        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            phase = (p < 2) ? PH_FILL : phase_t'($urandom_range(0, 3));
            req_idling <= $urandom_range(0, 3) != 0;
            rsp_idling <= $urandom_range(0, 3) != 0;
            for (int i = 0; i < PHASE_LEN; i++)
                send_random_request(phase);
        end
        req_ch.valid <= 1'b0;

        // Wait for every predicted result, then a few quiet cycles
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d renames, %0d completes, %0d retires and %0d no-ops.",
                 sent_by_op[OP_RENAME], sent_by_op[OP_COMPLETE],
                 sent_by_op[OP_RETIRE], sent_by_op[OP_NOP]);
        $display("Buffer full on %0d renames; %0d entries retired, %0d retires refused.",
                 full_renames, retirements, refused_retires);
        if (mismatches == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

>>> files.f
hw/rtl/rru_pkg.sv
hw/rtl/rru_if.sv
hw/rtl/rob_register_rename_unit.sv
test/rru_checker.sv
test/tb.sv
